>>> rtl/ubce_pkg.sv
// ubce_pkg: shared constants and types of the serial boot command engine
// used by ubce_front, ubce_back and uart_boot_command_engine
`default_nettype none

package ubce_pkg;

    // image store geometry and read request limit
    localparam int unsigned MEM_BYTES  = 131072;
    localparam int unsigned ADDR_W     = $clog2(MEM_BYTES);
    localparam int unsigned READ_LIMIT = 2048;

    // command queue between the front and the back
    localparam int unsigned CMD_DEPTH = 4;
    localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);

    // result queue at the output
    localparam int unsigned RES_DEPTH = 4;
    localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);

    // command and reply bytes
    localparam logic [7:0] KEY_UPLOAD = 8'h55;  // 'U'
    localparam logic [7:0] KEY_READ   = 8'h52;  // 'R'
    localparam logic [7:0] KEY_JUMP   = 8'h4A;  // 'J'
    localparam logic [7:0] ACK_UPLOAD = 8'h55;
    localparam logic [7:0] ACK_READ   = 8'hAA;
    localparam logic [7:0] ERR_READ   = 8'hEE;
    localparam logic [7:0] ACK_JUMP   = 8'hCC;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;

    // operation kinds handed from the front to the back
    localparam logic [1:0] OP_TX    = 2'd0;  // single reply byte
    localparam logic [1:0] OP_WRITE = 2'd1;  // upload byte, maybe with final ack
    localparam logic [1:0] OP_READ  = 2'd2;  // readback payload byte
    localparam logic [1:0] OP_QUERY = 2'd3;  // unknown command: '?', CR, LF

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        tx_byte;   // reply byte for OP_TX
        logic              jump;      // jump request for OP_TX
        logic              flag;      // final upload byte or final read byte
        logic              wr_en;     // upload byte lands inside the store
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } cmd_t;

    typedef struct packed {
        logic              tx_valid;
        logic [7:0]        tx_byte;
        logic              write_valid;
        logic [ADDR_W-1:0] write_offset;
        logic [7:0]        write_data;
        logic              jump_request;
        logic              read_done;
        logic              last;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/uart_boot_command_engine.sv
// uart_boot_command_engine: serial boot command engine, top level
// depends on ubce_pkg, ubce_front, ubce_back (and ubce_ram through ubce_back)
//
// Input channel: push/full. A word is a received byte (action 0, rx_byte) or
// a free transmit slot (action 1). Output channel: empty/pop, a queue of
// result words; the oldest one sits on the result ports while empty is low.
// A word may cause zero to three result words; last marks the final one.
// The parser accepts one word per cycle while full is low, into a four-entry
// operation queue; the back end drains one operation per cycle, unless the
// result queue is full, through the 128 KiB image store (one write or one
// registered read per cycle) into a four-entry result queue. The first result
// word passes the operation queue, the result stage register and the result
// queue on its way to the result ports; an unknown command holds the back end
// until its three reply bytes are queued.
// After reset the store is swept to zero, one byte per cycle; full stays
// high until the sweep ends. When the receiver stops popping, the result
// queue and then the operation queue fill and full rises; nothing is lost.
`default_nettype none

module uart_boot_command_engine (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic                         action,
    input  wire logic [7:0]                   rx_byte,
    output logic                              empty,
    input  wire logic                         pop,
    output logic                              tx_valid,
    output logic      [7:0]                   tx_byte,
    output logic                              write_valid,
    output logic      [ubce_pkg::ADDR_W-1:0]  write_offset,
    output logic      [7:0]                   write_data,
    output logic                              jump_request,
    output logic                              read_done,
    output logic                              last
);

    logic           clear_busy;
    logic           cmd_empty;
    logic           cmd_pop;
    ubce_pkg::cmd_t cmd_head;
    ubce_pkg::res_t res_head;

    // parser and operation queue
    ubce_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .action     (action),
        .rx_byte    (rx_byte),
        .clear_busy (clear_busy),
        .cmd_pop    (cmd_pop),
        .cmd_empty  (cmd_empty),
        .cmd_head   (cmd_head)
    );

    // store access and result queue
    ubce_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear_busy (clear_busy),
        .cmd_empty  (cmd_empty),
        .cmd_head   (cmd_head),
        .cmd_pop    (cmd_pop),
        .res_empty  (empty),
        .res_pop    (pop),
        .res_head   (res_head)
    );

    // result fields
    assign tx_valid     = res_head.tx_valid;
    assign tx_byte      = res_head.tx_byte;
    assign write_valid  = res_head.write_valid;
    assign write_offset = res_head.write_offset;
    assign write_data   = res_head.write_data;
    assign jump_request = res_head.jump_request;
    assign read_done    = res_head.read_done;
    assign last         = res_head.last;

endmodule

`default_nettype wire

>>> rtl/ubce_ram.sv
// ubce_ram: generic single write port, single read port RAM with registered read
// no dependencies
`default_nettype none

module ubce_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/ubce_front.sv
// ubce_front: command parser, takes input words and queues store operations
// depends on ubce_pkg
`default_nettype none

module ubce_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic          action,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          clear_busy,
    input  wire logic          cmd_pop,
    output logic               cmd_empty,
    output ubce_pkg::cmd_t     cmd_head
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_UP_LEN  = 3'd1;
    localparam logic [2:0] PH_UP_DATA = 3'd2;
    localparam logic [2:0] PH_RD_OFF  = 3'd3;
    localparam logic [2:0] PH_RD_LEN  = 3'd4;
    localparam logic [2:0] PH_RD_SEND = 3'd5;

    localparam int unsigned AW = ubce_pkg::ADDR_W;
    localparam int unsigned CW = ubce_pkg::CMD_PTR_W;

    logic [2:0]    phase_reg,  phase_next;
    logic [1:0]    fcnt_reg,   fcnt_next;
    logic [31:0]   word_reg,   word_next;
    logic [31:0]   roff_reg,   roff_next;
    logic [31:0]   remain_reg, remain_next;
    logic [31:0]   uptr_reg,   uptr_next;
    logic [AW-1:0] rptr_reg,   rptr_next;

    ubce_pkg::cmd_t cmd_mem_reg [ubce_pkg::CMD_DEPTH];
    logic [CW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW:0]    cnt_reg,    cnt_next;

    logic           accept;
    logic           cmd_push;
    ubce_pkg::cmd_t cmd_in;
    logic [31:0]    field_word;
    logic           field_done;
    logic [32:0]    rd_end;
    logic           rd_bad;

    // queue status and input handshake
    assign full      = clear_busy || (cnt_reg == (CW+1)'(ubce_pkg::CMD_DEPTH));
    assign cmd_empty = (cnt_reg == '0);
    assign cmd_head  = cmd_mem_reg[rd_ptr_reg];
    assign accept    = push && !full;

    // little-endian field assembly and read request check
    assign field_word = word_reg | (32'(rx_byte) << {fcnt_reg, 3'b000});
    assign field_done = (fcnt_reg == 2'd3);
    assign rd_end     = {1'b0, roff_reg} + {1'b0, field_word};
    assign rd_bad     = (field_word > 32'(ubce_pkg::READ_LIMIT))
                        || (rd_end > 33'(ubce_pkg::MEM_BYTES));

    // parser
    always_comb
    begin
        phase_next  = phase_reg;
        fcnt_next   = fcnt_reg;
        word_next   = word_reg;
        roff_next   = roff_reg;
        remain_next = remain_reg;
        uptr_next   = uptr_reg;
        rptr_next   = rptr_reg;
        cmd_push    = 1'b0;
        cmd_in      = '0;

        if (accept)
        begin
            if (action)
            begin
                // transmit slot releases one payload byte
                if (phase_reg == PH_RD_SEND)
                begin
                    cmd_push     = 1'b1;
                    cmd_in.kind  = ubce_pkg::OP_READ;
                    cmd_in.addr  = rptr_reg;
                    cmd_in.flag  = (remain_reg == 32'd1);
                    rptr_next    = rptr_reg + AW'(1);
                    remain_next  = remain_reg - 32'd1;
                    if (remain_reg == 32'd1)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        word_next = '0;
                        fcnt_next = '0;
                        priority if (rx_byte == ubce_pkg::KEY_UPLOAD)
                        begin
                            phase_next = PH_UP_LEN;
                        end
                        else if (rx_byte == ubce_pkg::KEY_READ)
                        begin
                            phase_next = PH_RD_OFF;
                        end
                        else if (rx_byte == ubce_pkg::KEY_JUMP)
                        begin
                            cmd_push       = 1'b1;
                            cmd_in.kind    = ubce_pkg::OP_TX;
                            cmd_in.tx_byte = ubce_pkg::ACK_JUMP;
                            cmd_in.jump    = 1'b1;
                        end
                        else
                        begin
                            cmd_push    = 1'b1;
                            cmd_in.kind = ubce_pkg::OP_QUERY;
                        end
                    end
                    PH_UP_LEN:
                    begin
                        fcnt_next = fcnt_reg + 2'd1;
                        word_next = field_word;
                        if (field_done)
                        begin
                            word_next   = '0;
                            remain_next = field_word;
                            uptr_next   = '0;
                            if (field_word == '0)
                            begin
                                phase_next     = PH_IDLE;
                                cmd_push       = 1'b1;
                                cmd_in.kind    = ubce_pkg::OP_TX;
                                cmd_in.tx_byte = ubce_pkg::ACK_UPLOAD;
                            end
                            else
                            begin
                                phase_next = PH_UP_DATA;
                            end
                        end
                    end
                    PH_UP_DATA:
                    begin
                        cmd_in.kind  = ubce_pkg::OP_WRITE;
                        cmd_in.wr_en = (uptr_reg < 32'(ubce_pkg::MEM_BYTES));
                        cmd_in.flag  = (remain_reg == 32'd1);
                        cmd_in.addr  = uptr_reg[AW-1:0];
                        cmd_in.data  = rx_byte;
                        cmd_push     = cmd_in.wr_en || cmd_in.flag;
                        uptr_next    = uptr_reg + 32'd1;
                        remain_next  = remain_reg - 32'd1;
                        if (remain_reg == 32'd1)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_RD_OFF:
                    begin
                        fcnt_next = fcnt_reg + 2'd1;
                        word_next = field_word;
                        if (field_done)
                        begin
                            word_next  = '0;
                            roff_next  = field_word;
                            phase_next = PH_RD_LEN;
                        end
                    end
                    PH_RD_LEN:
                    begin
                        fcnt_next = fcnt_reg + 2'd1;
                        word_next = field_word;
                        if (field_done)
                        begin
                            word_next   = '0;
                            phase_next  = PH_IDLE;
                            cmd_push    = 1'b1;
                            cmd_in.kind = ubce_pkg::OP_TX;
                            if (rd_bad)
                            begin
                                cmd_in.tx_byte = ubce_pkg::ERR_READ;
                            end
                            else
                            begin
                                cmd_in.tx_byte = ubce_pkg::ACK_READ;
                                if (field_word != '0)
                                begin
                                    remain_next = field_word;
                                    rptr_next   = roff_reg[AW-1:0];
                                    phase_next  = PH_RD_SEND;
                                end
                            end
                        end
                    end
                    PH_RD_SEND:
                    begin
                        // received bytes ignored while payload is pending
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // command queue pointers
    always_comb
    begin
        wr_ptr_next = cmd_push ? wr_ptr_reg + CW'(1) : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? rd_ptr_reg + CW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + (CW+1)'(cmd_push) - (CW+1)'(cmd_pop);
    end

    // command queue storage
    always_ff @(posedge clk)
    begin
        if (cmd_push)
        begin
            cmd_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    // parser state and queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            fcnt_reg   <= '0;
            word_reg   <= '0;
            roff_reg   <= '0;
            remain_reg <= '0;
            uptr_reg   <= '0;
            rptr_reg   <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            fcnt_reg   <= fcnt_next;
            word_reg   <= word_next;
            roff_reg   <= roff_next;
            remain_reg <= remain_next;
            uptr_reg   <= uptr_next;
            rptr_reg   <= rptr_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ubce_back.sv
// ubce_back: clears and accesses the image store, builds result words
// depends on ubce_pkg and ubce_ram
`default_nettype none

module ubce_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    output logic                clear_busy,
    input  wire logic           cmd_empty,
    input  wire ubce_pkg::cmd_t cmd_head,
    output logic                cmd_pop,
    output logic                res_empty,
    input  wire logic           res_pop,
    output ubce_pkg::res_t      res_head
);

    localparam int unsigned AW = ubce_pkg::ADDR_W;
    localparam int unsigned RW = ubce_pkg::RES_PTR_W;

    logic [AW-1:0]  clr_cnt_reg,  clr_cnt_next;
    logic           clr_busy_reg, clr_busy_next;

    logic           b_valid_reg, b_valid_next;
    ubce_pkg::cmd_t b_cmd_reg;
    logic [1:0]     b_sub_reg,   b_sub_next;

    ubce_pkg::res_t res_mem_reg [ubce_pkg::RES_DEPTH];
    logic [RW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [RW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [RW:0]    cnt_reg,    cnt_next;

    logic           res_full;
    logic           res_push;
    ubce_pkg::res_t res_in;
    logic           b_done;
    logic           issue;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata;
    logic           ram_re;
    logic [7:0]     ram_rdata;

    assign clear_busy = clr_busy_reg;

    // clearing pass over the store after reset
    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(ubce_pkg::MEM_BYTES - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    // issue stage: take the next operation once the result stage frees up
    assign res_full  = (cnt_reg == (RW+1)'(ubce_pkg::RES_DEPTH));
    assign res_empty = (cnt_reg == '0);
    assign res_head  = res_mem_reg[rd_ptr_reg];
    assign res_push  = b_valid_reg && !res_full;
    assign b_done    = res_push
                       && ((b_cmd_reg.kind != ubce_pkg::OP_QUERY) || (b_sub_reg == 2'd2));
    assign issue     = !cmd_empty && !clr_busy_reg && (!b_valid_reg || b_done);
    assign cmd_pop   = issue;

    // store port selection
    assign ram_we    = clr_busy_reg
                       || (issue && (cmd_head.kind == ubce_pkg::OP_WRITE) && cmd_head.wr_en);
    assign ram_waddr = clr_busy_reg ? clr_cnt_reg : cmd_head.addr;
    assign ram_wdata = clr_busy_reg ? 8'h00 : cmd_head.data;
    assign ram_re    = issue && (cmd_head.kind == ubce_pkg::OP_READ);

    ubce_ram #(
        .WIDTH (8),
        .DEPTH (ubce_pkg::MEM_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cmd_head.addr),
        .rdata (ram_rdata)
    );

    // result stage word build
    always_comb
    begin
        res_in = '0;
        unique case (b_cmd_reg.kind)
            ubce_pkg::OP_TX:
            begin
                res_in.tx_valid     = 1'b1;
                res_in.tx_byte      = b_cmd_reg.tx_byte;
                res_in.jump_request = b_cmd_reg.jump;
                res_in.last         = 1'b1;
            end
            ubce_pkg::OP_WRITE:
            begin
                res_in.tx_valid    = b_cmd_reg.flag;
                res_in.tx_byte     = b_cmd_reg.flag ? ubce_pkg::ACK_UPLOAD : 8'h00;
                res_in.write_valid = b_cmd_reg.wr_en;
                res_in.write_offset = b_cmd_reg.wr_en ? b_cmd_reg.addr : '0;
                res_in.write_data  = b_cmd_reg.wr_en ? b_cmd_reg.data : 8'h00;
                res_in.last        = 1'b1;
            end
            ubce_pkg::OP_READ:
            begin
                res_in.tx_valid  = 1'b1;
                res_in.tx_byte   = ram_rdata;
                res_in.read_done = b_cmd_reg.flag;
                res_in.last      = 1'b1;
            end
            ubce_pkg::OP_QUERY:
            begin
                res_in.tx_valid = 1'b1;
                unique case (b_sub_reg)
                    2'd0:    res_in.tx_byte = ubce_pkg::CH_QMARK;
                    2'd1:    res_in.tx_byte = ubce_pkg::CH_CR;
                    default: res_in.tx_byte = ubce_pkg::CH_LF;
                endcase
                res_in.last = (b_sub_reg == 2'd2);
            end
            default:
            begin
                res_in = '0;
            end
        endcase
    end

    // result stage occupancy and reply step
    always_comb
    begin
        b_valid_next = b_valid_reg;
        b_sub_next   = b_sub_reg;
        if (issue)
        begin
            b_valid_next = 1'b1;
            b_sub_next   = 2'd0;
        end
        else if (b_done)
        begin
            b_valid_next = 1'b0;
        end
        else if (res_push)
        begin
            b_sub_next = b_sub_reg + 2'd1;
        end
    end

    // result queue pointers
    always_comb
    begin
        wr_ptr_next = res_push ? wr_ptr_reg + RW'(1) : wr_ptr_reg;
        rd_ptr_next = (res_pop && !res_empty) ? rd_ptr_reg + RW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + (RW+1)'(res_push) - (RW+1)'(res_pop && !res_empty);
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_cmd_reg <= cmd_head;
        end
        if (res_push)
        begin
            res_mem_reg[wr_ptr_reg] <= res_in;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
            b_valid_reg  <= 1'b0;
            b_sub_reg    <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
            b_valid_reg  <= b_valid_next;
            b_sub_reg    <= b_sub_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            cnt_reg      <= cnt_next;
        end
    end

endmodule

`default_nettype wire
